>>> hw/rtl/uerm_pkg.sv
`timescale 1ns / 1ps

package uerm_pkg;

    localparam int DEF_SAMPLE_COUNT = 5;
    localparam int DEF_COUNT_BITS   = 16;

    localparam int DIST_BITS        = 10;
    localparam logic [DIST_BITS-1:0] MAX_DIST_RESET = 10'd400;

    localparam int TRIG_LOW_TICKS   = 2;
    localparam int TRIG_HIGH_TICKS  = 12;

    // 0.0172 cm/tick in tenths: w*172/1000 == w*43/250
    localparam int SCALE_NUM        = 43;
    localparam int SCALE_DEN        = 250;
    localparam int DECIMAL_BASE     = 10;
    localparam int ROUND_LIMIT      = 7;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_LOW  = 3'd1,
        PH_HIGH = 3'd2,
        PH_WAIT = 3'd3,
        PH_MEAS = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        CS_RUN   = 3'd0,
        CS_MUL   = 3'd1,
        CS_SCALE = 3'd2,
        CS_DIV   = 3'd3,
        CS_MUL10 = 3'd4,
        CS_ROUND = 3'd5,
        CS_EMIT  = 3'd6
    } ctrl_state_t;

    typedef struct packed {
        logic tick_en;
        logic ld_mul;
        logic ld_scale;
        logic ld_div;
        logic ld_mul10;
        logic ld_round;
        logic out_ld_tick;
        logic out_ld_done;
    } ctrl_cmd_t;

    typedef struct packed {
        logic meas_done;
        logic trigger;
        logic busy;
    } tick_sts_t;

endpackage

>>> hw/rtl/uerm_ifs.sv
`timescale 1ns / 1ps

interface uerm_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic echo_level;

    modport source (output valid, start_req, echo_level, input ready);
    modport sink   (input valid, start_req, echo_level, output ready);
endinterface

interface uerm_out_if;
    logic                           valid;
    logic                           ready;
    logic                           trigger_level;
    logic [uerm_pkg::DIST_BITS-1:0] distance_cm;
    logic                           done_res;
    logic                           busy_res;

    modport source (output valid, trigger_level, distance_cm, done_res, busy_res,
                    input ready);
    modport sink   (input valid, trigger_level, distance_cm, done_res, busy_res,
                    output ready);
endinterface

interface uerm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [uerm_pkg::DIST_BITS-1:0] max_distance_cm;

    modport source (output valid, max_distance_cm, input ready);
    modport sink   (input valid, max_distance_cm, output ready);
endinterface

>>> hw/rtl/ultrasonic_echo_ranger_median.sv
`timescale 1ns / 1ps
// Ordinary tick: result registered the cycle after acceptance; one tick per cycle while
// output is not stalled. Completing tick (last echo fall): result passes MUL, SCALE, DIV,
// MUL10, ROUND, EMIT: two reciprocal multiply/correct passes; no tick taken meanwhile.
// Reset (rst_n low, async): idle, counters and output valid cleared, max distance 400;
// stored echo widths are undefined until written.
module ultrasonic_echo_ranger_median #(
    parameter int SAMPLE_COUNT = uerm_pkg::DEF_SAMPLE_COUNT,
    parameter int COUNT_BITS   = uerm_pkg::DEF_COUNT_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    uerm_in_if.sink     ticks,
    uerm_out_if.source  results,
    uerm_cfg_if.sink    cfg
);

    uerm_pkg::ctrl_cmd_t   cmd;
    uerm_pkg::tick_sts_t   sts;
    logic [COUNT_BITS-1:0] median;

    assign cfg.ready = 1'b1;

    uerm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ticks.valid),
        .in_ready  (ticks.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    uerm_tick #(
        .SAMPLE_COUNT (SAMPLE_COUNT),
        .COUNT_BITS   (COUNT_BITS)
    ) u_tick (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_en    (cmd.tick_en),
        .start_req  (ticks.start_req),
        .echo_level (ticks.echo_level),
        .sts        (sts),
        .median     (median)
    );

    uerm_conv #(
        .COUNT_BITS (COUNT_BITS)
    ) u_conv (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .median        (median),
        .cfg_we        (cfg.valid),
        .cfg_data      (cfg.max_distance_cm),
        .trigger_level (results.trigger_level),
        .distance_cm   (results.distance_cm),
        .done_res      (results.done_res),
        .busy_res      (results.busy_res)
    );

endmodule

>>> hw/rtl/uerm_ctrl.sv
`timescale 1ns / 1ps

module uerm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  uerm_pkg::tick_sts_t  sts,
    output uerm_pkg::ctrl_cmd_t  cmd
);

    uerm_pkg::ctrl_state_t state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  can_load;

    assign can_load  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= uerm_pkg::CS_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            uerm_pkg::CS_RUN:
            begin
                if (in_valid && can_load && sts.meas_done)
                    state_next = uerm_pkg::CS_MUL;
            end
            uerm_pkg::CS_MUL:   state_next = uerm_pkg::CS_SCALE;
            uerm_pkg::CS_SCALE: state_next = uerm_pkg::CS_DIV;
            uerm_pkg::CS_DIV:   state_next = uerm_pkg::CS_MUL10;
            uerm_pkg::CS_MUL10: state_next = uerm_pkg::CS_ROUND;
            uerm_pkg::CS_ROUND: state_next = uerm_pkg::CS_EMIT;
            uerm_pkg::CS_EMIT:
            begin
                if (can_load)
                    state_next = uerm_pkg::CS_RUN;
            end
            default:            state_next = uerm_pkg::CS_RUN;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            uerm_pkg::CS_RUN:
            begin
                in_ready        = can_load;
                cmd.tick_en     = in_valid && can_load;
                // the completing tick is reported after the conversion
                cmd.out_ld_tick = in_valid && can_load && !sts.meas_done;
            end
            uerm_pkg::CS_MUL:   cmd.ld_mul   = 1'b1;
            uerm_pkg::CS_SCALE: cmd.ld_scale = 1'b1;
            uerm_pkg::CS_DIV:   cmd.ld_div   = 1'b1;
            uerm_pkg::CS_MUL10: cmd.ld_mul10 = 1'b1;
            uerm_pkg::CS_ROUND: cmd.ld_round = 1'b1;
            uerm_pkg::CS_EMIT:  cmd.out_ld_done = can_load;
            default:            cmd = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.out_ld_tick || cmd.out_ld_done)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

endmodule

>>> hw/rtl/uerm_tick.sv
`timescale 1ns / 1ps

module uerm_tick #(
    parameter int SAMPLE_COUNT = uerm_pkg::DEF_SAMPLE_COUNT,
    parameter int COUNT_BITS   = uerm_pkg::DEF_COUNT_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tick_en,
    input  logic                  start_req,
    input  logic                  echo_level,
    output uerm_pkg::tick_sts_t   sts,
    output logic [COUNT_BITS-1:0] median
);

    localparam int IDX_BITS = $clog2(SAMPLE_COUNT);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    uerm_pkg::phase_t      phase_reg, phase_next;
    logic [COUNT_BITS-1:0] tick_count_reg, tick_count_next;
    logic [IDX_BITS-1:0]   sample_index_reg, sample_index_next;
    logic [COUNT_BITS-1:0] count_inc;
    logic                  ins_en;

    // widths kept in ascending order; only the first sample_index entries are live
    logic [COUNT_BITS-1:0] sorted_reg [SAMPLE_COUNT];
    logic [COUNT_BITS-1:0] sorted_next [SAMPLE_COUNT];
    logic                  le [SAMPLE_COUNT];

    assign count_inc = tick_count_reg + COUNT_BITS'(1);
    assign median    = sorted_reg[SAMPLE_COUNT/2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= uerm_pkg::PH_IDLE;
            tick_count_reg   <= '0;
            sample_index_reg <= '0;
        end
        else if (tick_en)
        begin
            phase_reg        <= phase_next;
            tick_count_reg   <= tick_count_next;
            sample_index_reg <= sample_index_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_en && ins_en)
            sorted_reg <= sorted_next;
    end

    always_comb
    begin
        for (int k = 0; k < SAMPLE_COUNT; k++)
            le[k] = (IDX_BITS'(k) < sample_index_reg) && (sorted_reg[k] <= tick_count_reg);
        sorted_next[0] = le[0] ? sorted_reg[0] : tick_count_reg;
        for (int k = 1; k < SAMPLE_COUNT; k++)
        begin
            if (le[k])
                sorted_next[k] = sorted_reg[k];
            else if (le[k-1])
                sorted_next[k] = tick_count_reg;
            else
                sorted_next[k] = sorted_reg[k-1];
        end
    end

    // next state
    always_comb
    begin
        phase_next        = phase_reg;
        tick_count_next   = tick_count_reg;
        sample_index_next = sample_index_reg;
        ins_en            = 1'b0;
        unique case (phase_reg)
            uerm_pkg::PH_LOW:
            begin
                tick_count_next = count_inc;
                if (count_inc >= COUNT_BITS'(uerm_pkg::TRIG_LOW_TICKS))
                begin
                    phase_next      = uerm_pkg::PH_HIGH;
                    tick_count_next = '0;
                end
            end
            uerm_pkg::PH_HIGH:
            begin
                tick_count_next = count_inc;
                if (count_inc >= COUNT_BITS'(uerm_pkg::TRIG_HIGH_TICKS))
                begin
                    phase_next      = uerm_pkg::PH_WAIT;
                    tick_count_next = '0;
                end
            end
            uerm_pkg::PH_WAIT:
            begin
                if (echo_level)
                begin
                    phase_next      = uerm_pkg::PH_MEAS;
                    tick_count_next = COUNT_BITS'(1);
                end
            end
            uerm_pkg::PH_MEAS:
            begin
                if (echo_level)
                begin
                    if (tick_count_reg != CNT_MAX)
                        tick_count_next = count_inc;
                end
                else
                begin
                    ins_en          = 1'b1;
                    tick_count_next = '0;
                    if (sample_index_reg == IDX_BITS'(SAMPLE_COUNT - 1))
                    begin
                        phase_next        = uerm_pkg::PH_IDLE;
                        sample_index_next = '0;
                    end
                    else
                    begin
                        phase_next        = uerm_pkg::PH_LOW;
                        sample_index_next = sample_index_reg + IDX_BITS'(1);
                    end
                end
            end
            default:
            begin
                phase_next = uerm_pkg::PH_IDLE;
                if (start_req)
                begin
                    phase_next        = uerm_pkg::PH_LOW;
                    tick_count_next   = '0;
                    sample_index_next = '0;
                end
            end
        endcase
    end

    // per-tick outputs, from the phase at tick start
    always_comb
    begin
        sts = '0;
        unique case (phase_reg)
            uerm_pkg::PH_LOW:  sts.busy = 1'b1;
            uerm_pkg::PH_HIGH:
            begin
                sts.busy    = 1'b1;
                sts.trigger = 1'b1;
            end
            uerm_pkg::PH_WAIT: sts.busy = 1'b1;
            uerm_pkg::PH_MEAS:
            begin
                sts.busy      = 1'b1;
                sts.meas_done = !echo_level
                                && (sample_index_reg == IDX_BITS'(SAMPLE_COUNT - 1));
            end
            default:           sts = '0;
        endcase
    end

endmodule

>>> hw/rtl/uerm_conv.sv
`timescale 1ns / 1ps

module uerm_conv #(
    parameter int COUNT_BITS = uerm_pkg::DEF_COUNT_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  uerm_pkg::ctrl_cmd_t            cmd,
    input  uerm_pkg::tick_sts_t            sts,
    input  logic [COUNT_BITS-1:0]          median,
    input  logic                           cfg_we,
    input  logic [uerm_pkg::DIST_BITS-1:0] cfg_data,
    output logic                           trigger_level,
    output logic [uerm_pkg::DIST_BITS-1:0] distance_cm,
    output logic                           done_res,
    output logic                           busy_res
);

    localparam int DB         = uerm_pkg::DIST_BITS;
    // width * 43
    localparam int P_BITS     = COUNT_BITS + 6;
    // divide by 250 via floor reciprocal; estimate is exact or one short
    localparam int S250       = P_BITS + 2;
    localparam int M250_BITS  = S250 - 7;
    localparam logic [63:0] M250_FULL = (64'd1 << S250) / 64'(uerm_pkg::SCALE_DEN);
    localparam int PROD_BITS  = P_BITS + M250_BITS;
    localparam int T_BITS     = P_BITS - 7;
    // divide tenths by 10, same scheme
    localparam int S10        = T_BITS + 2;
    localparam int M10_BITS   = S10 - 3;
    localparam logic [63:0] M10_FULL = (64'd1 << S10) / 64'(uerm_pkg::DECIMAL_BASE);
    localparam int PROD10_BITS = T_BITS + M10_BITS;
    localparam int C_BITS     = T_BITS - 3;
    localparam int REM_BITS   = 5;
    localparam int CMP_BITS   = (C_BITS > DB) ? C_BITS : DB;

    logic [P_BITS-1:0]      p_reg;
    logic [PROD_BITS-1:0]   prod_reg;
    logic [T_BITS-1:0]      tenths_reg, tenths_next;
    logic [PROD10_BITS-1:0] prod10_reg;
    logic [C_BITS-1:0]      cm_reg, cm_next;
    logic [DB-1:0]          max_dist_reg;

    logic                   trigger_reg, done_reg, busy_reg;
    logic [DB-1:0]          dist_reg, dist_clamped;

    logic [T_BITS-1:0]      q0;
    logic [P_BITS-1:0]      rem250;
    logic [C_BITS-1:0]      c0;
    logic [REM_BITS-1:0]    rem0, rem1;
    logic                   fix10, round_up;
    logic [CMP_BITS-1:0]    cm_ext, max_ext;

    assign q0          = prod_reg[S250 +: T_BITS];
    assign rem250      = p_reg - P_BITS'(q0) * P_BITS'(uerm_pkg::SCALE_DEN);
    assign tenths_next = q0 + T_BITS'(rem250 >= P_BITS'(uerm_pkg::SCALE_DEN));

    assign c0       = prod10_reg[S10 +: C_BITS];
    assign rem0     = REM_BITS'(tenths_reg - T_BITS'(c0) * T_BITS'(uerm_pkg::DECIMAL_BASE));
    assign fix10    = rem0 >= REM_BITS'(uerm_pkg::DECIMAL_BASE);
    assign rem1     = fix10 ? rem0 - REM_BITS'(uerm_pkg::DECIMAL_BASE) : rem0;
    assign round_up = rem1 > REM_BITS'(uerm_pkg::ROUND_LIMIT);
    assign cm_next  = c0 + C_BITS'(fix10) + C_BITS'(round_up);

    assign cm_ext       = CMP_BITS'(cm_reg);
    assign max_ext      = CMP_BITS'(max_dist_reg);
    assign dist_clamped = (cm_ext > max_ext) ? max_dist_reg : DB'(cm_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_dist_reg <= uerm_pkg::MAX_DIST_RESET;
        else if (cfg_we)
            max_dist_reg <= cfg_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_mul)
            p_reg <= P_BITS'(median) * P_BITS'(uerm_pkg::SCALE_NUM);
        if (cmd.ld_scale)
            prod_reg <= PROD_BITS'(p_reg) * PROD_BITS'(M250_FULL[M250_BITS-1:0]);
        if (cmd.ld_div)
            tenths_reg <= tenths_next;
        if (cmd.ld_mul10)
            prod10_reg <= PROD10_BITS'(tenths_reg) * PROD10_BITS'(M10_FULL[M10_BITS-1:0]);
        if (cmd.ld_round)
            cm_reg <= cm_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_ld_tick)
        begin
            trigger_reg <= sts.trigger;
            dist_reg    <= '0;
            done_reg    <= 1'b0;
            busy_reg    <= sts.busy;
        end
        else if (cmd.out_ld_done)
        begin
            trigger_reg <= 1'b0;
            dist_reg    <= dist_clamped;
            done_reg    <= 1'b1;
            busy_reg    <= 1'b1;
        end
    end

    assign trigger_level = trigger_reg;
    assign distance_cm   = dist_reg;
    assign done_res      = done_reg;
    assign busy_res      = busy_reg;

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int          SAMPLES     = uerm_pkg::DEF_SAMPLE_COUNT;
    localparam int unsigned COUNT_MAX   = (1 << uerm_pkg::DEF_COUNT_BITS) - 1;
    localparam int          TRIG_TICKS  = uerm_pkg::TRIG_LOW_TICKS + uerm_pkg::TRIG_HIGH_TICKS;
    localparam int          SEG_TICKS   = 100;
    localparam int          SETTLE      = 10;
    localparam int          STALL_LIMIT = 2000;
    localparam int          PRINT_LIMIT = 40;

    typedef struct packed {
        logic start;
        logic echo;
    } tick_in_t;

    typedef struct packed {
        logic                           trig;
        logic [uerm_pkg::DIST_BITS-1:0] dist_cm;
        logic                           done;
        logic                           busy;
    } tick_res_t;

    logic clk = 1'b0;
    logic rst_n;

    uerm_in_if  tk ();
    uerm_out_if rs ();
    uerm_cfg_if cf ();

    ultrasonic_echo_ranger_median dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .ticks   (tk),
        .results (rs),
        .cfg     (cf)
    );

    always #4 clk = ~clk;

    tick_in_t  pending [$];
    tick_res_t awaited [$];
    tick_in_t  on_bus;

    int send_gap_pct;
    int recv_gap_pct;
    int mismatches;
    int seq_ticks;
    int stall_cycles;

    // ranger model state
    uerm_pkg::phase_t               rng_phase;
    int unsigned                    rng_count;
    int unsigned                    rng_idx;
    int unsigned                    rng_widths [SAMPLES];
    logic [uerm_pkg::DIST_BITS-1:0] depth_cm;

    function automatic void step_ranger(tick_in_t t);
        tick_res_t   r;
        int unsigned srt [SAMPLES];
        int unsigned tmp;
        int unsigned tenths;
        int unsigned cm;
        r = '0;
        r.busy = 1'b1;
        case (rng_phase)
            uerm_pkg::PH_LOW:
            begin
                rng_count++;
                if (rng_count >= uerm_pkg::TRIG_LOW_TICKS)
                begin
                    rng_phase = uerm_pkg::PH_HIGH;
                    rng_count = 0;
                end
            end
            uerm_pkg::PH_HIGH:
            begin
                r.trig = 1'b1;
                rng_count++;
                if (rng_count >= uerm_pkg::TRIG_HIGH_TICKS)
                begin
                    rng_phase = uerm_pkg::PH_WAIT;
                    rng_count = 0;
                end
            end
            uerm_pkg::PH_WAIT:
            begin
                if (t.echo)
                begin
                    rng_phase = uerm_pkg::PH_MEAS;
                    rng_count = 1;
                end
            end
            uerm_pkg::PH_MEAS:
            begin
                if (t.echo)
                begin
                    if (rng_count < COUNT_MAX)
                        rng_count++;
                end
                else
                begin
                    rng_widths[rng_idx] = rng_count;
                    rng_idx++;
                    rng_count = 0;
                    if (rng_idx >= SAMPLES)
                    begin
                        srt = rng_widths;
                        for (int i = 0; i < SAMPLES - 1; i++)
                            for (int j = 0; j < SAMPLES - 1 - i; j++)
                                if (srt[j] > srt[j+1])
                                begin
                                    tmp = srt[j];
                                    srt[j] = srt[j+1];
                                    srt[j+1] = tmp;
                                end
                        // w*172/1000 in tenths of a cm
                        tenths = srt[SAMPLES/2] * uerm_pkg::SCALE_NUM / uerm_pkg::SCALE_DEN;
                        cm = tenths / uerm_pkg::DECIMAL_BASE;
                        if (tenths % uerm_pkg::DECIMAL_BASE > uerm_pkg::ROUND_LIMIT)
                            cm++;
                        if (cm > depth_cm)
                            cm = depth_cm;
                        r.dist_cm = cm[uerm_pkg::DIST_BITS-1:0];
                        r.done = 1'b1;
                        rng_phase = uerm_pkg::PH_IDLE;
                        rng_idx = 0;
                    end
                    else
                        rng_phase = uerm_pkg::PH_LOW;
                end
            end
            default:
            begin
                r.busy = 1'b0;
                rng_phase = uerm_pkg::PH_IDLE;
                if (t.start)
                begin
                    rng_phase = uerm_pkg::PH_LOW;
                    rng_count = 0;
                    rng_idx = 0;
                end
            end
        endcase
        awaited.push_back(r);
    endfunction

    task automatic flag_mismatch(string msg);
        if (mismatches < PRINT_LIMIT)
            $display("%0t mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // tick driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tk.valid && tk.ready)
                step_ranger(on_bus);
            if (!tk.valid || tk.ready)
            begin
                if (pending.size() > 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    on_bus = pending.pop_front();
                    tk.valid      <= 1'b1;
                    tk.start_req  <= on_bus.start;
                    tk.echo_level <= on_bus.echo;
                end
                else
                    tk.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        tick_res_t want;
        if (rst_n)
        begin
            if (rs.valid && rs.ready)
            begin
                if (awaited.size() == 0)
                    flag_mismatch("result transaction with nothing awaited");
                else
                begin
                    want = awaited.pop_front();
                    if (rs.trigger_level !== want.trig)
                        flag_mismatch($sformatf("trigger_level got %b want %b",
                                                rs.trigger_level, want.trig));
                    if (rs.distance_cm !== want.dist_cm)
                        flag_mismatch($sformatf("distance_cm got %0d want %0d",
                                                rs.distance_cm, want.dist_cm));
                    if (rs.done_res !== want.done)
                        flag_mismatch($sformatf("done_res got %b want %b",
                                                rs.done_res, want.done));
                    if (rs.busy_res !== want.busy)
                        flag_mismatch($sformatf("busy_res got %b want %b",
                                                rs.busy_res, want.busy));
                end
            end
            rs.ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // watchdog: cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((tk.valid && tk.ready) || (rs.valid && rs.ready) || (cf.valid && cf.ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb failed");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic push_tick(logic s, logic e);
        tick_in_t t;
        t.start = s;
        t.echo = e;
        pending.push_back(t);
    endtask

    // idle noise, then the start request
    task automatic add_start();
        repeat ($urandom_range(3, 0))
            push_tick(1'b0, 1'($urandom_range(1)));
        push_tick(1'b1, 1'($urandom_range(1)));
    endtask

    // one ranging cycle: trigger ticks carry noise, start is ignored while busy
    task automatic add_cycle(int unsigned wait_ticks, int unsigned width_ticks);
        repeat (TRIG_TICKS)
            push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        repeat (wait_ticks)
            push_tick(1'($urandom_range(1)), 1'b0);
        repeat (width_ticks)
            push_tick(1'($urandom_range(1)), 1'b1);
        push_tick(1'($urandom_range(1)), 1'b0);
        seq_ticks += TRIG_TICKS + wait_ticks + width_ticks + 1;
    endtask

    task automatic add_random_measurement();
        int unsigned roll;
        int unsigned wait_ticks;
        int unsigned width_ticks;
        add_start();
        repeat (SAMPLES)
        begin
            roll = $urandom_range(99);
            if (roll < 70)
                wait_ticks = $urandom_range(3, 0);
            else if (roll < 95)
                wait_ticks = $urandom_range(12, 4);
            else
                wait_ticks = $urandom_range(40, 13);
            roll = $urandom_range(99);
            if (roll < 80)
                width_ticks = $urandom_range(24, 1);
            else if (roll < 95)
                width_ticks = $urandom_range(60, 25);
            else
                width_ticks = $urandom_range(200, 61);
            add_cycle(wait_ticks, width_ticks);
        end
    endtask

    task automatic drain_all();
        while (pending.size() != 0 || awaited.size() != 0 || tk.valid)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_depth(logic [uerm_pkg::DIST_BITS-1:0] value);
        @(posedge clk);
        cf.valid           <= 1'b1;
        cf.max_distance_cm <= value;
        do
            @(posedge clk);
        while (!cf.ready);
        cf.valid <= 1'b0;
        depth_cm = value;
    endtask

    initial
    begin
        rst_n              = 1'b0;
        tk.valid           = 1'b0;
        tk.start_req       = 1'b0;
        tk.echo_level      = 1'b0;
        rs.ready           = 1'b0;
        cf.valid           = 1'b0;
        cf.max_distance_cm = '0;
        send_gap_pct       = 0;
        recv_gap_pct       = 0;
        mismatches         = 0;
        seq_ticks          = 0;
        stall_cycles       = 0;
        rng_phase          = uerm_pkg::PH_IDLE;
        rng_count          = 0;
        rng_idx            = 0;
        depth_cm           = uerm_pkg::MAX_DIST_RESET;
        foreach (rng_widths[i])
            rng_widths[i] = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int seg = 0; seg < 6; seg++)
        begin
            if (seg < 2)
            begin
                send_gap_pct = 8;
                recv_gap_pct = 76;
            end
            else if (seg < 4)
            begin
                send_gap_pct = 76;
                recv_gap_pct = 8;
            end
            else
            begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end

            case (seg)
                1: write_depth(10'd1);
                2: write_depth(10'd0);
                3: write_depth(10'($urandom_range(60, 2)));
                4: write_depth(10'd1023);
                5: write_depth(10'($urandom_range(1023, 0)));
                default: ;
            endcase

            seq_ticks = 0;
            if (seg == 0)
            begin
                // median 47 -> tenths digit 8, rounds up to 1 cm;
                // echo already high on the first wait tick
                add_start();
                add_cycle(0, 1);
                add_cycle(0, 47);
                add_cycle(3, 47);
                add_cycle(1, 46);
                add_cycle(2, 47);
                // median 46 -> tenths digit 7, stays at 0 cm
                add_start();
                add_cycle(0, 46);
                add_cycle(5, 46);
                add_cycle(0, 46);
                add_cycle(1, 2);
                add_cycle(0, 3);
                // sender holds off until everything is back
                drain_all();
            end

            while (seq_ticks < SEG_TICKS)
                add_random_measurement();
            drain_all();
        end

        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

>>> ultrasonic_echo_ranger_median.f
hw/rtl/uerm_pkg.sv
hw/rtl/uerm_ifs.sv
hw/rtl/uerm_ctrl.sv
hw/rtl/uerm_tick.sv
hw/rtl/uerm_conv.sv
hw/rtl/ultrasonic_echo_ranger_median.sv
bench/tb.sv
